// ===== sv/ffjp_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the first-fit job placer.
// Depends on nothing; the RTL files other than ffjp_ram use scoped names, the bench imports it.
package ffjp_pkg;

	localparam int SIZE_W  = 16;  // job size and resource level
	localparam int CAP_W   = 16;  // capacity register
	localparam int RIU_W   = 5;   // resources-in-use register
	localparam int ROUND_W = 16;  // round counter
	localparam int IDX_W   = 4;   // reported resource index
	localparam int OUTC_W  = 2;   // outcome code
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;
	localparam int QUEUE_DEPTH = 2;  // command queue between front and engine

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_CAPACITY    = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_RES_IN_USE  = 1'b1;
	localparam logic [RIU_W-1:0]     RES_IN_USE_RST  = 5'd16;

	// request function codes
	localparam logic FUNC_JOB   = 1'b0;
	localparam logic FUNC_ROUND = 1'b1;

	typedef enum logic [OUTC_W-1:0] {
		OUT_PLACED   = 2'd0,
		OUT_DEFERRED = 2'd1,
		OUT_DROPPED  = 2'd2
	} outcome_t;

	typedef enum logic [1:0] {
		ENG_IDLE,
		ENG_READ,
		ENG_FIT,
		ENG_DECIDE
	} eng_state_t;

	typedef struct packed {
		logic              is_round;
		logic [SIZE_W-1:0] size;
	} cmd_t;

	typedef struct packed {
		logic [SIZE_W-1:0]  job_size;
		logic [IDX_W-1:0]   resource_index;
		outcome_t           outcome;
		logic [ROUND_W-1:0] round_number;
		logic               last;
	} result_t;

endpackage

// ===== sv/ffjp_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package needed.
module ffjp_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== sv/ffjp_front.sv =====
`timescale 1ns / 1ps
// Front end: accepts requests, classifies them and queues them for the engine.
// Depends on ffjp_pkg.
module ffjp_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic                       func,
	input  logic [ffjp_pkg::SIZE_W-1:0] job_size,
	output logic                       cmd_valid,
	output ffjp_pkg::cmd_t             cmd,
	input  logic                       cmd_pop
);

	localparam int PW = $clog2(ffjp_pkg::QUEUE_DEPTH);
	localparam int CW = $clog2(ffjp_pkg::QUEUE_DEPTH + 1);

	ffjp_pkg::cmd_t entry_q [ffjp_pkg::QUEUE_DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;
	logic           push;
	logic           pop;
	ffjp_pkg::cmd_t in_cmd;

	assign in_ready  = (count_q != CW'(ffjp_pkg::QUEUE_DEPTH));
	assign push      = in_valid && in_ready;
	assign cmd_valid = (count_q != '0);
	assign pop       = cmd_pop && cmd_valid;
	assign cmd       = entry_q[rd_ptr_q];

	always_comb begin
		in_cmd.is_round = (func == ffjp_pkg::FUNC_ROUND);
		in_cmd.size     = job_size;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= in_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= PW'(wr_ptr_q + PW'(1));
			end
			if (pop) begin
				rd_ptr_q <= PW'(rd_ptr_q + PW'(1));
			end
			case ({push, pop})
				2'b10:   count_q <= CW'(count_q + CW'(1));
				2'b01:   count_q <= CW'(count_q - CW'(1));
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== sv/ffjp_engine.sv =====
`timescale 1ns / 1ps
// Back end: resource levels, first-fit placement, hold queue replay, result register.
// Depends on ffjp_pkg and ffjp_ram.
module ffjp_engine #(
	parameter int MAX_RESOURCES = 16,
	parameter int HOLD_DEPTH    = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cmd_valid,
	input  ffjp_pkg::cmd_t                cmd,
	output logic                          cmd_pop,
	input  logic [ffjp_pkg::CAP_W-1:0]    capacity,
	input  logic [ffjp_pkg::RIU_W-1:0]    res_in_use,
	output logic                          res_valid,
	output ffjp_pkg::result_t             res,
	input  logic                          res_ready
);

	localparam int AW = $clog2(HOLD_DEPTH);
	localparam int CW = $clog2(HOLD_DEPTH + 1);
	localparam int SW = ffjp_pkg::SIZE_W;

	ffjp_pkg::eng_state_t state_q, state_d;

	logic [SW-1:0]                   level_q [MAX_RESOURCES];
	logic [MAX_RESOURCES-1:0]        fit_q;
	logic [MAX_RESOURCES-1:0]        fits;
	logic [MAX_RESOURCES-1:0]        mask;
	logic [MAX_RESOURCES-1:0]        first_hot;
	logic                            any_fit;
	logic [ffjp_pkg::IDX_W-1:0]      hit_idx;
	logic [SW-1:0]                   size_q;
	logic                            replay_q;
	logic [CW-1:0]                   held_count_q;
	logic [CW-1:0]                   rd_ptr_q;
	logic [CW-1:0]                   rd_next;
	logic [CW-1:0]                   kept_q;
	logic [CW-1:0]                   kept_next;
	logic [ffjp_pkg::ROUND_W-1:0]    round_q;
	logic                            hold_full;
	logic                            replay_last;
	logic                            start_job;
	logic                            start_round;
	logic                            decide;
	logic                            res_valid_q;
	ffjp_pkg::result_t               res_q;
	ffjp_pkg::outcome_t              outc;

	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [AW-1:0] ram_raddr;
	logic [SW-1:0] ram_rdata;

	ffjp_ram #(
		.WIDTH(SW),
		.DEPTH(HOLD_DEPTH)
	) u_hold (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(size_q),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign rd_next     = CW'(rd_ptr_q + CW'(1));
	assign replay_last = (rd_next == held_count_q);
	assign hold_full   = (held_count_q == CW'(HOLD_DEPTH));

	// parallel compare and lowest-index pick
	always_comb begin
		for (int i = 0; i < MAX_RESOURCES; i++) begin
			mask[i] = (32'(i) < 32'(res_in_use));
			fits[i] = (size_q <= level_q[i]) && mask[i];
		end
		first_hot = fit_q & (~fit_q + MAX_RESOURCES'(1));
		any_fit   = |fit_q;
		hit_idx   = '0;
		for (int i = 0; i < MAX_RESOURCES; i++) begin
			if (first_hot[i]) begin
				hit_idx = hit_idx | ffjp_pkg::IDX_W'(i);
			end
		end
		if (any_fit) begin
			outc = ffjp_pkg::OUT_PLACED;
		end else if (replay_q || !hold_full) begin
			outc = ffjp_pkg::OUT_DEFERRED;
		end else begin
			outc = ffjp_pkg::OUT_DROPPED;
		end
		kept_next = any_fit ? kept_q : CW'(kept_q + CW'(1));
	end

	// sequencer
	always_comb begin
		state_d     = state_q;
		cmd_pop     = 1'b0;
		start_job   = 1'b0;
		start_round = 1'b0;
		decide      = 1'b0;
		case (state_q)
			ffjp_pkg::ENG_IDLE: begin
				if (cmd_valid) begin
					cmd_pop = 1'b1;
					if (cmd.is_round) begin
						start_round = 1'b1;
						if (held_count_q != '0) begin
							state_d = ffjp_pkg::ENG_READ;
						end
					end else begin
						start_job = 1'b1;
						state_d   = ffjp_pkg::ENG_FIT;
					end
				end
			end
			ffjp_pkg::ENG_READ: begin
				state_d = ffjp_pkg::ENG_FIT;
			end
			ffjp_pkg::ENG_FIT: begin
				state_d = ffjp_pkg::ENG_DECIDE;
			end
			ffjp_pkg::ENG_DECIDE: begin
				if (!res_valid_q || res_ready) begin
					decide = 1'b1;
					if (replay_q && !replay_last) begin
						state_d = ffjp_pkg::ENG_READ;
					end else begin
						state_d = ffjp_pkg::ENG_IDLE;
					end
				end
			end
			default: state_d = ffjp_pkg::ENG_IDLE;
		endcase
		ram_raddr = decide ? rd_next[AW-1:0] : '0;
		ram_we    = decide && !any_fit && (replay_q || !hold_full);
		ram_waddr = replay_q ? kept_q[AW-1:0] : held_count_q[AW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ffjp_pkg::ENG_IDLE;
			replay_q     <= 1'b0;
			held_count_q <= '0;
			rd_ptr_q     <= '0;
			kept_q       <= '0;
			round_q      <= '0;
			res_valid_q  <= 1'b0;
			for (int i = 0; i < MAX_RESOURCES; i++) begin
				level_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (start_job) begin
				replay_q <= 1'b0;
			end
			if (start_round) begin
				replay_q <= (held_count_q != '0);
				rd_ptr_q <= '0;
				kept_q   <= '0;
				round_q  <= ffjp_pkg::ROUND_W'(round_q + ffjp_pkg::ROUND_W'(1));
				for (int i = 0; i < MAX_RESOURCES; i++) begin
					if (mask[i]) begin
						level_q[i] <= capacity;
					end
				end
			end
			if (decide) begin
				if (any_fit) begin
					for (int i = 0; i < MAX_RESOURCES; i++) begin
						if (first_hot[i]) begin
							level_q[i] <= SW'(level_q[i] - size_q);
						end
					end
				end
				if (replay_q) begin
					rd_ptr_q <= rd_next;
					kept_q   <= kept_next;
					if (replay_last) begin
						held_count_q <= kept_next;
					end
				end else if (!any_fit && !hold_full) begin
					held_count_q <= CW'(held_count_q + CW'(1));
				end
			end
			if (decide) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers without reset
	always_ff @(posedge clk) begin
		if (start_job) begin
			size_q <= cmd.size;
		end else if (state_q == ffjp_pkg::ENG_READ) begin
			size_q <= ram_rdata;
		end
		if (state_q == ffjp_pkg::ENG_FIT) begin
			fit_q <= fits;
		end
		if (decide) begin
			res_q.job_size       <= size_q;
			res_q.resource_index <= any_fit ? hit_idx : '0;
			res_q.outcome        <= outc;
			res_q.round_number   <= round_q;
			res_q.last           <= !replay_q || replay_last;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

// ===== sv/first_fit_job_placer_core.sv =====
`timescale 1ns / 1ps
// Top level of the first-fit job placer: configuration registers and port wiring.
// Depends on ffjp_pkg, ffjp_front, ffjp_engine (and through it ffjp_ram).

// A job request is placed on the lowest-numbered resource in use whose
// remaining level covers it, deferred into the hold queue, or dropped when
// that queue is full; it yields one result with last set. A new-round
// request bumps the round counter, refills the resources in use to the
// capacity register and replays every held job oldest first, one result per
// job, last on the final one (no result when nothing is held). Requests sit
// in a two-entry queue, so the input side keeps taking requests while that
// queue has room, also while the engine works or a result waits on the output
// register. A job is picked up, all levels are compared in parallel, then the
// pick and level update are made; a round is picked up, then each held job
// gets a registered read of the hold RAM before the same compare and update
// steps. Output back-pressure stalls both. Levels live in flops; the hold
// queue is a RAM of HOLD_DEPTH entries. Configuration writes go through
// cfg_wen/cfg_index/cfg_data and must only be issued while the block is idle.
module first_fit_job_placer_core #(
	parameter int MAX_RESOURCES = 16,
	parameter int HOLD_DEPTH    = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// configuration
	input  logic                             cfg_wen,
	input  logic [ffjp_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [ffjp_pkg::CFG_DATA_W-1:0]  cfg_data,
	// request channel
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic                             func,
	input  logic [ffjp_pkg::SIZE_W-1:0]      job_size,
	// result channel
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [ffjp_pkg::SIZE_W-1:0]      job_size_out,
	output logic [ffjp_pkg::IDX_W-1:0]       resource_index,
	output logic [ffjp_pkg::OUTC_W-1:0]      outcome,
	output logic [ffjp_pkg::ROUND_W-1:0]     round_number,
	output logic                             last
);

	logic [ffjp_pkg::CAP_W-1:0] capacity_q;
	logic [ffjp_pkg::RIU_W-1:0] res_in_use_q;
	logic                       cmd_valid;
	logic                       cmd_pop;
	ffjp_pkg::cmd_t             cmd;
	ffjp_pkg::result_t          res;

	// configuration registers, written when cfg_wen is high; no read-back
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q   <= '0;
			res_in_use_q <= ffjp_pkg::RES_IN_USE_RST;
		end else if (cfg_wen) begin
			case (cfg_index)
				ffjp_pkg::REG_CAPACITY:   capacity_q   <= cfg_data[ffjp_pkg::CAP_W-1:0];
				ffjp_pkg::REG_RES_IN_USE: res_in_use_q <= cfg_data[ffjp_pkg::RIU_W-1:0];
				default: ;
			endcase
		end
	end

	// front: request acceptance and command queue
	ffjp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.func     (func),
		.job_size (job_size),
		.cmd_valid(cmd_valid),
		.cmd      (cmd),
		.cmd_pop  (cmd_pop)
	);

	// back: placement engine with hold queue and result register
	ffjp_engine #(
		.MAX_RESOURCES(MAX_RESOURCES),
		.HOLD_DEPTH   (HOLD_DEPTH)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.capacity  (capacity_q),
		.res_in_use(res_in_use_q),
		.res_valid (out_valid),
		.res       (res),
		.res_ready (out_ready)
	);

	assign job_size_out   = res.job_size;
	assign resource_index = res.resource_index;
	assign outcome        = res.outcome;
	assign round_number   = res.round_number;
	assign last           = res.last;

endmodule

// ===== tb/first_fit_job_placer_core_test.sv =====
`timescale 1ns / 1ps
// Self-checking bench for first_fit_job_placer_core: directed table, then random phases.
// Depends on ffjp_pkg and the placer RTL; needs no files or arguments.
module first_fit_job_placer_core_test;
	import ffjp_pkg::*;

	localparam int RES_SLOTS     = 16;        // DUT MAX_RESOURCES default
	localparam int HOLD_SLOTS    = 32;        // DUT HOLD_DEPTH default
	localparam int SETTLE_CYCLES = 24;        // empty-round latency plus request queue
	localparam int DRAIN_LIMIT   = 100000;    // cycles to wait for outstanding results
	localparam int LONG_HOLD     = 600;       // receiver hold-off, fills the request queue
	localparam int MAX_REPORTS   = 40;
	localparam longint TIMEOUT_NS = 64'd12_000_000;

	// ---------------------------------------------------------------- DUT ports
	logic                     clk        = 1'b0;
	logic                     arst_n     = 1'b0;
	logic                     cfg_wen    = 1'b0;
	logic [CFG_IDX_W-1:0]     cfg_index  = REG_CAPACITY;
	logic [CFG_DATA_W-1:0]    cfg_data   = '0;
	logic                     in_valid   = 1'b0;
	logic                     in_ready;
	logic                     func       = FUNC_JOB;
	logic [SIZE_W-1:0]        job_size   = '0;
	logic                     out_valid;
	logic                     out_ready  = 1'b0;
	logic [SIZE_W-1:0]        job_size_out;
	logic [IDX_W-1:0]         resource_index;
	logic [OUTC_W-1:0]        outcome;
	logic [ROUND_W-1:0]       round_number;
	logic                     last;

	first_fit_job_placer_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wen(cfg_wen),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.func(func),
		.job_size(job_size),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.job_size_out(job_size_out),
		.resource_index(resource_index),
		.outcome(outcome),
		.round_number(round_number),
		.last(last)
	);

	always #2 clk = ~clk;

	// ------------------------------------------------- placement predictor state
	// Mirrors the block: levels per resource, held jobs oldest first, round count
	// and the two registers (reset values: capacity 0, all 16 resources in use).
	logic [SIZE_W-1:0]  level_q [RES_SLOTS];
	logic [SIZE_W-1:0]  held_q[$];
	logic [ROUND_W-1:0] round_q   = '0;
	logic [CAP_W-1:0]   cap_q     = '0;
	logic [RIU_W-1:0]   in_use_q  = RES_IN_USE_RST;
	result_t            due_results[$];   // results still owed by the block, oldest first

	// knobs and tallies
	int gap_pct     = 0;   // chance per cycle that the request side idles
	int stall_pct   = 0;   // chance per cycle that the result side stalls
	int hold_reqs   = 0;   // bumped by the stimulus to ask for a long hold-off
	int holds_taken = 0;
	int hold_left   = 0;
	int n_mismatch  = 0;
	int n_requests  = 0;
	int n_rounds    = 0;
	int n_checked   = 0;
	int n_placed    = 0;
	int n_deferred  = 0;
	int n_dropped   = 0;

	initial begin
		foreach (level_q[i])
			level_q[i] = '0;
	end

	function automatic int resources_active();
		return (in_use_q > RES_SLOTS) ? RES_SLOTS : int'(in_use_q);
	endfunction

	// First fit: lowest resource in use whose level covers the job takes it.
	function automatic bit first_fit(input logic [SIZE_W-1:0] sz, output logic [IDX_W-1:0] spot);
		int n;
		n = resources_active();
		spot = '0;
		for (int i = 0; i < n; i++) begin
			if (sz <= level_q[i]) begin
				level_q[i] = level_q[i] - sz;
				spot = IDX_W'(i);
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	function automatic result_t result_of(input logic [SIZE_W-1:0] sz, input logic [IDX_W-1:0] spot,
			input outcome_t oc, input logic lst);
		result_t r;
		r.job_size       = sz;
		r.resource_index = spot;
		r.outcome        = oc;
		r.round_number   = round_q;
		r.last           = lst;
		return r;
	endfunction

	// Advances the predictor by one request and returns the results it causes.
	function automatic void placements_for(input logic f, input logic [SIZE_W-1:0] sz,
			ref result_t res[$]);
		logic [IDX_W-1:0]  spot;
		logic [SIZE_W-1:0] replay[$];
		int                n;
		res.delete();
		if (f == FUNC_JOB) begin
			if (first_fit(sz, spot))
				res.push_back(result_of(sz, spot, OUT_PLACED, 1'b1));
			else if (held_q.size() < HOLD_SLOTS) begin
				held_q.push_back(sz);
				res.push_back(result_of(sz, '0, OUT_DEFERRED, 1'b1));
			end else
				res.push_back(result_of(sz, '0, OUT_DROPPED, 1'b1));
			return;
		end
		// new round: bump count, refill the active resources, replay held jobs in order
		round_q = round_q + 1'b1;
		n = resources_active();
		for (int i = 0; i < n; i++)
			level_q[i] = cap_q;
		replay = held_q;
		held_q.delete();
		foreach (replay[i]) begin
			if (first_fit(replay[i], spot))
				res.push_back(result_of(replay[i], spot, OUT_PLACED, i == replay.size() - 1));
			else begin
				held_q.push_back(replay[i]);
				res.push_back(result_of(replay[i], '0, OUT_DEFERRED, i == replay.size() - 1));
			end
		end
	endfunction

	// ------------------------------------------------------------ request side
	// Valid goes up at a clock edge and stays until in_ready is seen with it.
	// On return we sit at the accepting edge with in_valid still high; the
	// caller's next action (another request, or settle) drives it in this step.
	task automatic send_request(input logic f, input logic [SIZE_W-1:0] sz,
			input bit typed = 1'b0, input result_t typed_res = '0);
		result_t got[$];
		while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		func     <= f;
		job_size <= sz;
		do
			@(posedge clk);
		while (!in_ready);
		placements_for(f, sz, got);
		// directed rows with a typed answer take that instead of the predictor's
		if (typed)
			due_results.push_back(typed_res);
		else
			foreach (got[i])
				due_results.push_back(got[i]);
		n_requests++;
		if (f == FUNC_ROUND)
			n_rounds++;
	endtask

	// Wait out every owed result, then tail more cycles: a round with nothing
	// held gives no result but may still be in flight.
	task automatic settle(input int tail);
		int waited;
		in_valid <= 1'b0;
		waited = 0;
		while (due_results.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		if (due_results.size() != 0) begin
			$display("%0t: %0d expected results never arrived", $time, due_results.size());
			n_mismatch++;
			due_results.delete();
		end
		repeat (tail) @(posedge clk);
	endtask

	// Both registers, back to back; only called while the block is idle.
	task automatic configure(input logic [CAP_W-1:0] cap, input logic [RIU_W-1:0] in_use);
		cfg_wen   <= 1'b1;
		cfg_index <= REG_CAPACITY;
		cfg_data  <= CFG_DATA_W'(cap);
		@(posedge clk);
		cfg_index <= REG_RES_IN_USE;
		cfg_data  <= CFG_DATA_W'(in_use);
		@(posedge clk);
		cfg_wen   <= 1'b0;
		cap_q    = cap;
		in_use_q = in_use;
	endtask

	// Sizes around the capacity, with a share of full-range values that mostly
	// fit nowhere and pile up in the hold queue.
	function automatic logic [SIZE_W-1:0] pick_job_size(input int wild_pct);
		int roll;
		roll = $urandom_range(99);
		if (roll < wild_pct)
			return SIZE_W'($urandom);
		if (roll < wild_pct + 5)
			return '0;
		if (roll < wild_pct + 10)
			return cap_q;
		if (cap_q == 0)
			return SIZE_W'($urandom_range(3));
		if (roll < 60)
			return SIZE_W'($urandom_range(cap_q / 3));
		return SIZE_W'($urandom_range(cap_q));
	endfunction

	task automatic random_phase(input logic [CAP_W-1:0] cap, input logic [RIU_W-1:0] in_use,
			input int items, input int round_pct, input int wild_pct, input bit squeeze);
		settle(SETTLE_CYCLES);
		configure(cap, in_use);
		if (squeeze)
			hold_reqs <= hold_reqs + 1;
		repeat (items) begin
			if ($urandom_range(99) < round_pct)
				send_request(FUNC_ROUND, SIZE_W'($urandom));
			else
				send_request(FUNC_JOB, pick_job_size(wild_pct));
		end
	endtask

	// ------------------------------------------------------------- result side
	// Random stalls, plus a long hold-off counted here when one is requested.
	always @(posedge clk) begin : result_sink
		if (holds_taken != hold_reqs) begin
			holds_taken = hold_reqs;
			hold_left   = LONG_HOLD;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else
			out_ready <= ($urandom_range(99) >= stall_pct);
	end

	function automatic void check_field(input string what, input int want, input int seen);
		if (want != seen) begin
			if (n_mismatch < MAX_REPORTS)
				$display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, seen);
			n_mismatch++;
		end
	endfunction

	always @(posedge clk) begin : result_check
		result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (due_results.size() == 0) begin
				if (n_mismatch < MAX_REPORTS)
					$display("%0t: result with none expected, got size %0h index %0h outcome %0d",
						$time, job_size_out, resource_index, outcome);
				n_mismatch++;
			end else begin
				want = due_results.pop_front();
				check_field("job_size_out", want.job_size, job_size_out);
				check_field("resource_index", want.resource_index, resource_index);
				check_field("outcome", want.outcome, outcome);
				check_field("round_number", want.round_number, round_number);
				check_field("last", want.last, last);
				n_checked++;
				case (want.outcome)
					OUT_PLACED:   n_placed++;
					OUT_DEFERRED: n_deferred++;
					default:      n_dropped++;
				endcase
			end
		end
	end

	// ---------------------------------------------------------- directed table
	typedef enum logic { ROW_REQ, ROW_CFG } row_kind_t;

	// For ROW_CFG, a is the capacity and b the resources in use.
	// For ROW_REQ, a is the job size; typed rows carry their result inline.
	typedef struct packed {
		row_kind_t          kind;
		logic               f;
		logic [SIZE_W-1:0]  a;
		logic [SIZE_W-1:0]  b;
		logic               typed;
		logic [IDX_W-1:0]   t_idx;
		outcome_t           t_outc;
		logic [ROUND_W-1:0] t_round;
	} row_t;

	localparam int N_STEPS = 23;

	row_t steps [N_STEPS] = '{
		// reset levels are zero: only a zero-size job fits, on resource 0
		'{ROW_REQ, FUNC_JOB,   16'h0000, 16'd0,  1'b1, 4'd0, OUT_PLACED,   16'd0},
		'{ROW_REQ, FUNC_JOB,   16'h0001, 16'd0,  1'b1, 4'd0, OUT_DEFERRED, 16'd0},
		'{ROW_REQ, FUNC_JOB,   16'hFFFF, 16'd0,  1'b1, 4'd0, OUT_DEFERRED, 16'd0},
		// round with reset capacity of zero: both held jobs held again
		'{ROW_REQ, FUNC_ROUND, 16'h1234, 16'd0,  1'b0, 4'd0, OUT_PLACED,   16'd0},
		'{ROW_CFG, FUNC_JOB,   16'hFFFF, 16'd16, 1'b0, 4'd0, OUT_PLACED,   16'd0},
		// full capacity: replay places both, largest job on its own resource
		'{ROW_REQ, FUNC_ROUND, 16'hA5A5, 16'd0,  1'b0, 4'd0, OUT_PLACED,   16'd0},
		'{ROW_REQ, FUNC_JOB,   16'hFFFF, 16'd0,  1'b0, 4'd0, OUT_PLACED,   16'd0},
		'{ROW_REQ, FUNC_JOB,   16'h8000, 16'd0,  1'b0, 4'd0, OUT_PLACED,   16'd0},
		// round with empty hold queue: no result at all
		'{ROW_REQ, FUNC_ROUND, 16'h0000, 16'd0,  1'b0, 4'd0, OUT_PLACED,   16'd0},
		// no resource in use: nothing fits, nothing is refilled
		'{ROW_CFG, FUNC_JOB,   16'd5,    16'd0,  1'b0, 4'd0, OUT_PLACED,   16'd0},
		'{ROW_REQ, FUNC_JOB,   16'h0000, 16'd0,  1'b1, 4'd0, OUT_DEFERRED, 16'd3},
		'{ROW_REQ, FUNC_ROUND, 16'hFFFF, 16'd0,  1'b0, 4'd0, OUT_PLACED,   16'd0},
		// resources in use past the top saturate to all of them
		'{ROW_CFG, FUNC_JOB,   16'd5,    16'd31, 1'b0, 4'd0, OUT_PLACED,   16'd0},
		'{ROW_REQ, FUNC_ROUND, 16'h5A5A, 16'd0,  1'b0, 4'd0, OUT_PLACED,   16'd0},
		'{ROW_REQ, FUNC_JOB,   16'd5,    16'd0,  1'b0, 4'd0, OUT_PLACED,   16'd0},
		'{ROW_REQ, FUNC_JOB,   16'd5,    16'd0,  1'b0, 4'd0, OUT_PLACED,   16'd0},
		'{ROW_REQ, FUNC_JOB,   16'd3,    16'd0,  1'b0, 4'd0, OUT_PLACED,   16'd0},
		'{ROW_REQ, FUNC_JOB,   16'd2,    16'd0,  1'b0, 4'd0, OUT_PLACED,   16'd0},
		'{ROW_REQ, FUNC_JOB,   16'd6,    16'd0,  1'b0, 4'd0, OUT_PLACED,   16'd0},
		// one resource: only resource 0 is refilled, the others keep their levels
		'{ROW_CFG, FUNC_JOB,   16'd1,    16'd1,  1'b0, 4'd0, OUT_PLACED,   16'd0},
		'{ROW_REQ, FUNC_ROUND, 16'h0F0F, 16'd0,  1'b0, 4'd0, OUT_PLACED,   16'd0},
		'{ROW_REQ, FUNC_JOB,   16'd1,    16'd0,  1'b0, 4'd0, OUT_PLACED,   16'd0},
		'{ROW_REQ, FUNC_JOB,   16'hFFFF, 16'd0,  1'b0, 4'd0, OUT_PLACED,   16'd0}
	};

	// ------------------------------------------------------------------ sequence
	initial begin : stimulus
		result_t typed_res;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part, at reset configuration first
		foreach (steps[i]) begin
			if (steps[i].kind == ROW_CFG) begin
				settle(SETTLE_CYCLES);
				configure(steps[i].a, RIU_W'(steps[i].b));
			end else begin
				typed_res.job_size       = steps[i].a;
				typed_res.resource_index = steps[i].t_idx;
				typed_res.outcome        = steps[i].t_outc;
				typed_res.round_number   = steps[i].t_round;
				typed_res.last           = 1'b1;
				send_request(steps[i].f, steps[i].a, steps[i].typed, typed_res);
			end
		end

		// light sender idling, heavy receiver stalls
		gap_pct   = 15;
		stall_pct = 48;
		random_phase(16'd100, 5'd4, 50, 15, 10, 1'b0);
		random_phase(16'hFFFF, 5'd16, 40, 15, 10, 1'b0);

		// swapped; a single small resource fills the hold queue and forces drops,
		// then the receiver holds off long enough to back up the request side
		gap_pct   = 48;
		stall_pct = 15;
		random_phase(16'd10, 5'd1, 70, 5, 30, 1'b0);
		random_phase(16'd40, 5'd16, 50, 20, 5, 1'b1);

		// no idling on either side
		gap_pct   = 0;
		stall_pct = 0;
		random_phase(16'd0, 5'd7, 20, 15, 10, 1'b0);
		random_phase(CAP_W'($urandom), RIU_W'($urandom_range(1, 16)), 60, 15, 10, 1'b0);

		settle(SETTLE_CYCLES);
		$display("Run: %0d requests incl. %0d rounds (final round count %0h); %0d results checked",
			n_requests, n_rounds, round_q, n_checked);
		$display("Outcomes: %0d placed, %0d deferred, %0d dropped; mismatches %0d",
			n_placed, n_deferred, n_dropped, n_mismatch);
		if (n_mismatch == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin : watchdog
		#(TIMEOUT_NS);
		$display("Timeout at %0t with %0d results outstanding", $time, due_results.size());
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
